// ----- hw/rtl/integer_to_radix_digits_macros.svh -----
// ----------------------------------------------------------------------------
// Integer to radix digits: assertion macros
// Shared assertion forms for the conversion block, clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define I2R_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Check a consequent in the cycle after its antecedent
`define I2R_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/i2r_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer to radix digits: package
// Widths, constants, register indexes, state and status types and the digit
// to ASCII mapping shared by the conversion block.
// ----------------------------------------------------------------------------
`default_nettype none

package i2r_pkg;

    // Default sizes
    localparam int DEF_VALUE_BITS = 31;
    localparam int DEF_MAX_DIGITS = 32;

    // Fixed field widths
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Dividend bits consumed by the divider per cycle
    localparam int DIV_STEP = 4;

    // Radix register
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

    // ASCII mapping
    localparam logic [CHAR_W-1:0]  ASCII_ZERO        = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_LETTER_BASE = 7'd55;
    localparam logic [RADIX_W-1:0] DECIMAL_LIMIT     = 6'd10;

    // Register indexes (word address)
    typedef enum logic [ADDR_W-3:0] {
        REG_RADIX = 1'b0
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Map one digit to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DECIMAL_LIMIT) begin
            return ASCII_ZERO + d_ext;
        end
        return ASCII_LETTER_BASE + d_ext;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/integer_to_radix_digits.sv -----
// ----------------------------------------------------------------------------
// Integer to radix digits: top level
// Converts a non-negative integer to ASCII digits in a configured radix.
// ----------------------------------------------------------------------------
// Usage:
//   Write the radix (2..36, out-of-range values saturate) over the APB port
//   at address 0 while the block is idle; reset sets it to ten.
//   Each beat on the s_ channel carries one value. The block answers with
//   one m_ beat per digit, most significant first, as '0'-'9' or 'A'-'Z',
//   with m_last on the least significant digit. Zero gives a single '0'.
//   At most MAX_DIGITS digits come out; the low ones are kept.
//   Flow: every digit costs one division in the shared divider; once all
//   digits of an item are divided, each moves from the digit stack to the
//   output register. s_ready is high only between items; the next value is
//   taken while the last digit still waits. A stalled receiver holds the
//   current digit in the output register and pauses the digit emission.
//   Reset empties the block and drops any beat in progress; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits
    import i2r_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [ADDR_W-1:0]     paddr,
    input  wire logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    // Input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VALUE_BITS-1:0] s_value,
    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAR_W-1:0]          m_digit_char,
    output logic                       m_last
);

`include "integer_to_radix_digits_macros.svh"

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    state_t                    state_reg, state_next;
    logic [RADIX_W-1:0]        radix_reg;
    logic [RADIX_W-1:0]        radix_eff;
    logic [RADIX_W-1:0]        digits_reg [MAX_DIGITS];
    logic [CNT_W-1:0]          count_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]         m_digit_char_reg;
    logic                      m_last_reg;

    logic                      cfg_write;
    logic                      accept;
    logic                      div_start;
    logic [VALUE_BITS-1:0]     div_dividend;
    logic [VALUE_BITS-1:0]     div_quotient;
    logic [RADIX_W-1:0]        div_remainder;
    div_stat_t                 div_stat;
    logic                      push;
    logic                      pop;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_W-1:2] == REG_RADIX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_write) begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_RADIX) begin
            prdata = DATA_W'(radix_reg);
        end
    end

    // Saturate the radix to the supported range
    always_comb begin
        if (radix_reg < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (radix_reg > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    // Shared divider
    i2r_div_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .radix     (radix_eff),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .stat      (div_stat)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, divider launch, digit push and pop
    always_comb begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = s_value;
        push         = 1'b0;
        pop          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                div_dividend = div_quotient;
                if (div_stat.done) begin
                    push = 1'b1;
                    if ((div_quotient == '0) || (count_reg == CNT_W'(MAX_DIGITS - 1))) begin
                        state_next = ST_EMIT;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    pop = 1'b1;
                    if (count_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Digit stack: push least significant first, pop most significant first
    always_ff @(posedge aclk) begin
        if (push) begin
            digits_reg[0] <= div_remainder;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                digits_reg[i] <= digits_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                digits_reg[i] <= digits_reg[i+1];
            end
            digits_reg[MAX_DIGITS-1] <= '0;
        end
    end

    // Digit count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (push) begin
            count_reg <= count_reg + 1'b1;
        end else if (pop) begin
            count_reg <= count_reg - 1'b1;
        end
    end

    // Output register: load on pop, drop once the beat is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_digit_char_reg <= digit_to_char(digits_reg[0]);
            m_last_reg       <= (count_reg == CNT_W'(1));
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_digit_char = m_digit_char_reg;
    assign m_last       = m_last_reg;

    // Checks
    `I2R_ASSERT_NEXT(a_accept_starts_div, accept, div_stat.busy,
        "divider not started after an accepted beat")
    `I2R_ASSERT_NOW(a_done_in_divide, div_stat.done,
        (state_reg == ST_DIVIDE) && !div_stat.busy,
        "divider finished outside the divide phase")
    `I2R_ASSERT_NOW(a_emit_has_digits, state_reg == ST_EMIT, count_reg != '0,
        "emit phase with an empty digit stack")
    `I2R_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_DIGITS),
        "digit count beyond stack depth")

endmodule

`default_nettype wire

// ----- hw/rtl/i2r_div_unit.sv -----
// ----------------------------------------------------------------------------
// Integer to radix digits: iterative divider
// Divides an unsigned value by a small radix, DIV_STEP quotient bits per
// cycle, and presents the quotient and remainder when done pulses.
// ----------------------------------------------------------------------------
`default_nettype none

module i2r_div_unit
    import i2r_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [RADIX_W-1:0]    radix,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic [RADIX_W-1:0]         remainder,
    output div_stat_t                  stat
);

    localparam int CHUNKS = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int WORK_W = CHUNKS * DIV_STEP;
    localparam int CNT_W  = $clog2(CHUNKS);

    logic [WORK_W-1:0]   work_reg;
    logic [RADIX_W-1:0]  rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [RADIX_W-1:0]  rem_next;
    logic [DIV_STEP-1:0] qbits;
    logic [RADIX_W:0]    trial;

    // Restoring division over one chunk of dividend bits
    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial = {rem_next, work_reg[WORK_W-1-i]};
            if (trial >= {1'b0, radix}) begin
                rem_next              = RADIX_W'(trial - {1'b0, radix});
                qbits[DIV_STEP-1-i]   = 1'b1;
            end else begin
                rem_next = trial[RADIX_W-1:0];
            end
        end
    end

    // Control: load on start, advance one chunk per cycle, pulse done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    // Datapath: dividend shifts out the top, quotient bits shift in below
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            work_reg <= {work_reg[WORK_W-DIV_STEP-1:0], qbits};
            rem_reg  <= rem_next;
        end else if (start) begin
            work_reg <= WORK_W'(dividend);
            rem_reg  <= '0;
        end
    end

    assign quotient  = work_reg[VALUE_BITS-1:0];
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
